// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

   // default element format: Q16.16 in 32 bits
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // cross product term: difference of two full products
   function automatic int cross_width(input int w);
      return 2 * w + 1;
   endfunction

   // determinant: cross term times element, summed over three
   function automatic int det_width(input int w);
      return 3 * w + 3;
   endfunction

   // divider numerator: cross magnitude scaled by 2^(2*frac)
   function automatic int num_width(input int w, input int f);
      return 2 * w + 1 + 2 * f;
   endfunction

endpackage

// ===== rtl/mi3_cross.sv =====
module mi3_cross
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [ELEM_WIDTH-1:0]            p1,
   input  logic signed [ELEM_WIDTH-1:0]            q2,
   input  logic signed [ELEM_WIDTH-1:0]            p2,
   input  logic signed [ELEM_WIDTH-1:0]            q1,
   output logic signed [cross_width(ELEM_WIDTH)-1:0] x_out
);

   localparam int W  = ELEM_WIDTH;
   localparam int CW = cross_width(ELEM_WIDTH);

   logic signed [2*W-1:0] s_ff;
   logic signed [2*W-1:0] t_ff;
   logic signed [CW-1:0]  x_ff;

   // stage 1: the two products, stage 2: their difference
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= p1 * q2;
         t_ff <= p2 * q1;
         x_ff <= $signed({s_ff[2*W-1], s_ff}) - $signed({t_ff[2*W-1], t_ff});
      end
   end

   assign x_out = x_ff;

endmodule

// ===== rtl/mi3_det.sv =====
module mi3_det
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       en,
   // third column, taken at the request edge
   input  logic signed [ELEM_WIDTH-1:0]               c_in [3],
   // a x b, registered in the cross product lanes
   input  logic signed [cross_width(ELEM_WIDTH)-1:0]  x_in [3],
   // divisor magnitude, one copy per divider step
   output logic [num_width(ELEM_WIDTH, FRAC_BITS)-1:0][det_width(ELEM_WIDTH)-1:0] dmag_pipe,
   output logic                                       dneg_out,
   output logic                                       dzero_out
);

   localparam int W  = ELEM_WIDTH;
   localparam int DW = det_width(ELEM_WIDTH);
   localparam int NW = num_width(ELEM_WIDTH, FRAC_BITS);

   logic signed [W-1:0]   c1_ff [3];
   logic signed [W-1:0]   c2_ff [3];
   logic signed [2*W+1:0] plo_ff [3];
   logic signed [2*W+1:0] pmid_ff [3];
   logic signed [W:0]     ptop_ff [3];
   logic signed [DW-1:0]  term_ff [3];
   logic signed [DW-1:0]  det_ff;
   logic [DW-1:0]         dmag_ff [NW];
   logic                  dneg_ff [NW+1];
   logic                  dzero_ff [NW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            // align the column with the cross product
            c1_ff[i] <= c_in[i];
            c2_ff[i] <= c1_ff[i];
            // split the cross term into W-bit slices and a sign bit
            plo_ff[i]  <= $signed({2'b00, x_in[i][W-1:0]}) * c2_ff[i];
            pmid_ff[i] <= $signed({2'b00, x_in[i][2*W-1:W]}) * c2_ff[i];
            ptop_ff[i] <= x_in[i][2*W] ? -$signed({c2_ff[i][W-1], c2_ff[i]})
                                       : '0;
            // rebuild each full term
            term_ff[i] <= DW'(plo_ff[i]) + (DW'(pmid_ff[i]) <<< W)
                          + (DW'(ptop_ff[i]) <<< (2 * W));
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
         // magnitude and flags of the determinant
         dmag_ff[0]  <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         dneg_ff[0]  <= det_ff[DW-1];
         dzero_ff[0] <= (det_ff == '0);
         for (int k = 1; k < NW; k++) begin
            dmag_ff[k] <= dmag_ff[k-1];
         end
         for (int k = 1; k <= NW; k++) begin
            dneg_ff[k]  <= dneg_ff[k-1];
            dzero_ff[k] <= dzero_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NW; k++) begin
         dmag_pipe[k] = dmag_ff[k];
      end
   end

   assign dneg_out  = dneg_ff[NW];
   assign dzero_out = dzero_ff[NW];

endmodule

// ===== rtl/mi3_lane.sv =====
module mi3_lane
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic signed [cross_width(ELEM_WIDTH)-1:0] x_in,
   input  logic [num_width(ELEM_WIDTH, FRAC_BITS)-1:0][det_width(ELEM_WIDTH)-1:0] dmag_pipe,
   input  logic                                      dneg,
   output logic [ELEM_WIDTH-1:0]                     val_out,
   output logic                                      sat_out
);

   localparam int W  = ELEM_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int CW = cross_width(ELEM_WIDTH);
   localparam int DW = det_width(ELEM_WIDTH);
   localparam int NW = num_width(ELEM_WIDTH, FRAC_BITS);

   logic signed [CW-1:0] x1_ff;
   logic signed [CW-1:0] x2_ff;
   logic signed [CW-1:0] x3_ff;
   logic [NW-1:0]        num_ff [NW+1];
   logic [DW-1:0]        rem_ff [NW+1];
   logic [W-1:0]         q_ff [NW+1];
   logic                 big_ff [NW+1];
   logic                 xneg_ff [NW+1];
   logic [CW-1:0]        xmag;
   logic                 neg;

   // wait for the determinant, then load the scaled magnitude
   assign xmag = x3_ff[CW-1] ? CW'(-x3_ff) : CW'(x3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff      <= x_in;
         x2_ff      <= x1_ff;
         x3_ff      <= x2_ff;
         num_ff[0]  <= {xmag, {(2*F){1'b0}}};
         rem_ff[0]  <= '0;
         q_ff[0]    <= '0;
         big_ff[0]  <= 1'b0;
         xneg_ff[0] <= x3_ff[CW-1];
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 1; j <= NW; j++) begin : g_step
      logic [DW:0] sh;
      logic        ge;

      assign sh = {rem_ff[j-1], num_ff[j-1][NW-1]};
      assign ge = (sh >= {1'b0, dmag_pipe[j-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? DW'(sh - {1'b0, dmag_pipe[j-1]}) : sh[DW-1:0];
            num_ff[j]  <= {num_ff[j-1][NW-2:0], 1'b0};
            q_ff[j]    <= {q_ff[j-1][W-2:0], ge};
            big_ff[j]  <= big_ff[j-1] | q_ff[j-1][W-1];
            xneg_ff[j] <= xneg_ff[j-1];
         end
      end
   end

   // sign and saturation
   assign neg = xneg_ff[NW] ^ dneg;

   always_comb begin
      if (neg) begin
         sat_out = big_ff[NW] | (q_ff[NW][W-1] & (|q_ff[NW][W-2:0]));
         val_out = sat_out ? {1'b1, {(W-1){1'b0}}} : W'(-q_ff[NW]);
      end else begin
         sat_out = big_ff[NW] | q_ff[NW][W-1];
         val_out = sat_out ? {1'b0, {(W-1){1'b1}}} : q_ff[NW];
      end
   end

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// 3x3 fixed-point matrix inverse (adjugate over determinant). One request per
// cycle is accepted unless the output stalls, one response per request, and
// no state between requests. The long part of the pipeline is the nine-lane
// pipelined restoring divider, one quotient bit per stage. Elements are signed
// with FRAC_BITS fraction bits (Q16.16 by default); each inverse element is
// truncated toward zero and saturated, with overflow set if any saturated. A
// zero determinant sets singular and forces all elements and overflow to 0.
// The whole pipeline stalls while a response waits and rsp_ready is low.
module matrix3x3_inverse
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ELEM_WIDTH-1:0] req_e00,
   input  logic [ELEM_WIDTH-1:0] req_e01,
   input  logic [ELEM_WIDTH-1:0] req_e02,
   input  logic [ELEM_WIDTH-1:0] req_e10,
   input  logic [ELEM_WIDTH-1:0] req_e11,
   input  logic [ELEM_WIDTH-1:0] req_e12,
   input  logic [ELEM_WIDTH-1:0] req_e20,
   input  logic [ELEM_WIDTH-1:0] req_e21,
   input  logic [ELEM_WIDTH-1:0] req_e22,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ELEM_WIDTH-1:0] rsp_r00,
   output logic [ELEM_WIDTH-1:0] rsp_r01,
   output logic [ELEM_WIDTH-1:0] rsp_r02,
   output logic [ELEM_WIDTH-1:0] rsp_r10,
   output logic [ELEM_WIDTH-1:0] rsp_r11,
   output logic [ELEM_WIDTH-1:0] rsp_r12,
   output logic [ELEM_WIDTH-1:0] rsp_r20,
   output logic [ELEM_WIDTH-1:0] rsp_r21,
   output logic [ELEM_WIDTH-1:0] rsp_r22,
   output logic                  rsp_singular,
   output logic                  rsp_overflow
);

   localparam int W   = ELEM_WIDTH;
   localparam int CW  = cross_width(ELEM_WIDTH);
   localparam int DW  = det_width(ELEM_WIDTH);
   localparam int NW  = num_width(ELEM_WIDTH, FRAC_BITS);
   localparam int LAT = 7 + NW;

   logic                 en;
   logic signed [W-1:0]  col [3][3];
   logic signed [CW-1:0] x [3][3];
   logic [NW-1:0][DW-1:0] dmag_pipe;
   logic                 dneg;
   logic                 dzero;
   logic [W-1:0]         val [3][3];
   logic [8:0]           sat;
   logic [LAT-1:0]       vld_ff;
   logic [W-1:0]         res_ff [3][3];
   logic                 singular_ff;
   logic                 overflow_ff;

   // global pipeline advance
   assign en        = ~vld_ff[LAT-1] | rsp_ready;
   assign req_ready = en;

   // columns of the matrix: col[c][r] is row r, column c
   assign col[0][0] = req_e00;
   assign col[1][0] = req_e01;
   assign col[2][0] = req_e02;
   assign col[0][1] = req_e10;
   assign col[1][1] = req_e11;
   assign col[2][1] = req_e12;
   assign col[0][2] = req_e20;
   assign col[1][2] = req_e21;
   assign col[2][2] = req_e22;

   // nine cross product lanes: row r is col[r+1] x col[r+2]
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar i = 0; i < 3; i++) begin : g_col
         mi3_cross #(.ELEM_WIDTH(W)) u_cross (
            .clock (clock),
            .en    (en),
            .p1    (col[(r+1)%3][(i+1)%3]),
            .q2    (col[(r+2)%3][(i+2)%3]),
            .p2    (col[(r+1)%3][(i+2)%3]),
            .q1    (col[(r+2)%3][(i+1)%3]),
            .x_out (x[r][i])
         );

         mi3_lane #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
            .clock     (clock),
            .en        (en),
            .x_in      (x[r][i]),
            .dmag_pipe (dmag_pipe),
            .dneg      (dneg),
            .val_out   (val[r][i]),
            .sat_out   (sat[r*3+i])
         );
      end
   end

   // determinant (a x b) . c, shared by all lanes
   mi3_det #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_det (
      .clock     (clock),
      .en        (en),
      .c_in      (col[2]),
      .x_in      (x[2]),
      .dmag_pipe (dmag_pipe),
      .dneg_out  (dneg),
      .dzero_out (dzero)
   );

   // request valid tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // merge lanes into the response register
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               res_ff[r][i] <= dzero ? '0 : val[r][i];
            end
         end
         singular_ff <= dzero;
         overflow_ff <= ~dzero & (|sat);
      end
   end

   assign rsp_valid    = vld_ff[LAT-1];
   assign rsp_r00      = res_ff[0][0];
   assign rsp_r01      = res_ff[0][1];
   assign rsp_r02      = res_ff[0][2];
   assign rsp_r10      = res_ff[1][0];
   assign rsp_r11      = res_ff[1][1];
   assign rsp_r12      = res_ff[1][2];
   assign rsp_r20      = res_ff[2][0];
   assign rsp_r21      = res_ff[2][1];
   assign rsp_r22      = res_ff[2][2];
   assign rsp_singular = singular_ff;
   assign rsp_overflow = overflow_ff;

   // a singular response carries no overflow and zeros in r00, r11, r22, r01, r20
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (!rsp_overflow && rsp_r00 == '0 &&
         rsp_r11 == '0 && rsp_r22 == '0 && rsp_r01 == '0 && rsp_r20 == '0))
      else $error("singular response with nonzero data");

   // a stalled response stays valid, with r00, overflow and singular stable
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_r00) &&
         $stable(rsp_overflow) && $stable(rsp_singular)))
      else $error("response changed while stalled");

   // no request taken while the output is blocked
   a_no_accept_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted during stall");

endmodule

// ===== sim/matrix3x3_inverse_tb.sv =====
module matrix3x3_inverse_tb
   import mi3_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW = ELEM_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 7 + 2 * EW + 1 + 2 * FB;
   localparam int WD_LIMIT = 4000;
   localparam int N_RANDOM = 500;
   localparam int LONG_HOLD = 400;

   // wide enough for every product, determinant and scaled numerator
   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic [8:0][EW-1:0] e;
   } matrix_type;

   typedef struct packed {
      logic [8:0][EW-1:0] r;
      logic               singular;
      logic               overflow;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [EW-1:0] req_e [9];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [EW-1:0] rsp_r [9];
   logic rsp_singular, rsp_overflow;

   matrix_type  pending_q [$];
   inverse_type inverse_q [$];
   int  errors = 0;
   bit  stim_done = 0;
   bit  quiet = 0;      // no idling in the last part of the run
   bit  hold_done = 0;
   int  sent = 0;

   initial begin
      foreach (req_e[i]) req_e[i] = '0;
   end

   always #5 clock = ~clock;

   matrix3x3_inverse DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_e00(req_e[0]), .req_e01(req_e[1]), .req_e02(req_e[2]),
      .req_e10(req_e[3]), .req_e11(req_e[4]), .req_e12(req_e[5]),
      .req_e20(req_e[6]), .req_e21(req_e[7]), .req_e22(req_e[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_r00(rsp_r[0]), .rsp_r01(rsp_r[1]), .rsp_r02(rsp_r[2]),
      .rsp_r10(rsp_r[3]), .rsp_r11(rsp_r[4]), .rsp_r12(rsp_r[5]),
      .rsp_r20(rsp_r[6]), .rsp_r21(rsp_r[7]), .rsp_r22(rsp_r[8]),
      .rsp_singular(rsp_singular), .rsp_overflow(rsp_overflow)
   );

   function automatic wide_type sx(input logic [EW-1:0] v);
      return wide_type'($signed(v));
   endfunction

   // adjugate over determinant, truncated toward zero and saturated
   function automatic inverse_type invert(input matrix_type m);
      inverse_type res;
      wide_type a [3][3];   // a[col][row]
      wide_type adj [3][3]; // adj[row][col]
      wide_type det, dmag, nmag, q, num;
      wide_type maxv, minmag;
      bit neg;
      int c0, c1;
      maxv = (wide_type'(1) <<< (EW - 1)) - 1;
      minmag = wide_type'(1) <<< (EW - 1);
      res = '0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            a[c][r] = sx(m.e[r * 3 + c]);
      // row k of the inverse is the cross product of the other two columns
      for (int k = 0; k < 3; k++) begin
         c0 = (k + 1) % 3;
         c1 = (k + 2) % 3;
         for (int i = 0; i < 3; i++)
            adj[k][i] = a[c0][(i + 1) % 3] * a[c1][(i + 2) % 3]
                      - a[c0][(i + 2) % 3] * a[c1][(i + 1) % 3];
      end
      det = adj[2][0] * a[2][0] + adj[2][1] * a[2][1] + adj[2][2] * a[2][2];
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      dmag = (det < 0) ? -det : det;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) begin
            num = adj[r][c] <<< (2 * FB);
            neg = (num < 0) != (det < 0);
            nmag = (num < 0) ? -num : num;
            q = nmag / dmag;
            if (neg) begin
               if (q > minmag) begin
                  q = minmag;
                  res.overflow = 1'b1;
               end
               q = -q;
            end else if (q > maxv) begin
               q = maxv;
               res.overflow = 1'b1;
            end
            res.r[r * 3 + c] = q[EW-1:0];
         end
      return res;
   endfunction

   function automatic logic [EW-1:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return EW'($urandom);
         1: return EW'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
         2: return EW'($signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1)));
         3: return {1'b1, {(EW-1){1'b0}}};
         4: return {1'b0, {(EW-1){1'b1}}};
         default: return EW'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   function automatic matrix_type diag(input logic [EW-1:0] d);
      matrix_type m;
      m = '0;
      m.e[0] = d;
      m.e[4] = d;
      m.e[8] = d;
      return m;
   endfunction

   // stimulus: directed corners, then random matrices
   initial begin
      matrix_type m;
      pending_q.push_back(diag(EW'(1 << FB)));             // identity
      pending_q.push_back('0);                             // zero: singular
      pending_q.push_back(diag({1'b1, {(EW-1){1'b0}}}));   // most negative
      pending_q.push_back(diag({1'b0, {(EW-1){1'b1}}}));   // most positive
      pending_q.push_back(diag(EW'(1)));                   // tiny: saturates
      pending_q.push_back(diag(EW'(-1)));                  // tiny negative
      pending_q.push_back(diag(EW'(-(2 << FB))));
      pending_q.push_back(diag({EW{1'b1}}));
      m = '0;                                              // permutation
      m.e[1] = EW'(1 << FB); m.e[5] = EW'(3 << FB); m.e[6] = EW'(-(1 << FB));
      pending_q.push_back(m);
      m = '0;                                              // equal rows
      for (int i = 0; i < 9; i++) m.e[i] = EW'((i % 3 + 1) << FB);
      pending_q.push_back(m);
      for (int i = 0; i < 9; i++) m.e[i] = {EW{1'b1}};     // all ones
      pending_q.push_back(m);
      for (int i = 0; i < 9; i++) m.e[i] = {1'b1, {(EW-1){1'b0}}};
      pending_q.push_back(m);
      m = diag(EW'(1 << FB));                              // upper triangular
      m.e[1] = {1'b0, {(EW-1){1'b1}}}; m.e[2] = {1'b1, {(EW-1){1'b0}}};
      pending_q.push_back(m);
      m = diag(EW'(1 << FB));                              // near singular
      m.e[3] = EW'((1 << FB) - 1); m.e[1] = EW'(1 << FB);
      pending_q.push_back(m);
      for (int n = 0; n < N_RANDOM; n++) begin
         for (int i = 0; i < 9; i++) m.e[i] = rand_elem();
         if ($urandom_range(0, 9) == 0) begin
            // make one row a copy of another: singular with random content
            for (int c = 0; c < 3; c++) m.e[6 + c] = m.e[c];
         end
         pending_q.push_back(m);
      end
   end

   // reset
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sent <= sent + 1;
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               m_drive(pending_q.pop_front());
               if (!quiet && $urandom_range(0, 5) == 0)
                  send_gap <= $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
         if (pending_q.size() < 60) quiet <= 1'b1;
      end
   end

   task automatic m_drive(input matrix_type m);
      matrix_type mq;
      mq = m;
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_e[i] <= mq.e[i];
      inverse_q.push_back(invert(mq));
   endtask

   // receiver: random stall bursts, one long hold-off after a while
   int stall = 0;
   int hold = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold > 0) begin
            hold <= hold - 1;
            rsp_ready <= 1'b0;
            if (hold == 1) hold_done <= 1'b1;
         end else if (!hold_done && sent > 150) begin
            hold <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0) stall <= $urandom_range(1, 16);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      inverse_type exp_inv;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inverse_q.size() == 0) begin
            $display("%0t: response with no request outstanding", $realtime);
            errors++;
         end else begin
            exp_inv = inverse_q.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_r[i] !== exp_inv.r[i]) begin
                  $display("%0t: r%0d%0d expected %h actual %h", $realtime,
                           i / 3, i % 3, exp_inv.r[i], rsp_r[i]);
                  errors++;
               end
            if (rsp_singular !== exp_inv.singular) begin
               $display("%0t: singular expected %b actual %b", $realtime,
                        exp_inv.singular, rsp_singular);
               errors++;
            end
            if (rsp_overflow !== exp_inv.overflow) begin
               $display("%0t: overflow expected %b actual %b", $realtime,
                        exp_inv.overflow, rsp_overflow);
               errors++;
            end
         end
      end
   end

   // watchdog and end of run
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (inverse_q.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
